>>> hw/rtl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMP(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");

// next-cycle implication
`define AST_NXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");

`endif

>>> hw/rtl/pch_pkg.sv
package pch_pkg;

   localparam int HULL_SIZE_BITS = 7;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_INS_CMP,
      ST_INS_PUT,
      ST_LR0,
      ST_LR1,
      ST_LR2,
      ST_CH_INIT,
      ST_CH_NEXT,
      ST_CH_GET,
      ST_PART_MUL,
      ST_PART_EVAL,
      ST_PUSH_CHK,
      ST_TURN_MUL,
      ST_TURN_EVAL,
      ST_POP_RD,
      ST_EMIT_RD,
      ST_EMIT_LD,
      ST_ECHO
   } state_type;

   typedef struct packed {
      logic neg;
      logic zero;
   } turn_sign_type;

endpackage

>>> hw/rtl/pch_cross.sv
// registered cross product a1*b1 - a2*b2, sign valid in the cycle after the operands
module pch_cross #(
   parameter int DW = 17
) (
   input  logic                   clock,
   input  logic signed [DW-1:0]   a1,
   input  logic signed [DW-1:0]   b1,
   input  logic signed [DW-1:0]   a2,
   input  logic signed [DW-1:0]   b2,
   output pch_pkg::turn_sign_type sign
);

   localparam int PW = 2 * DW;

   logic signed [PW-1:0] m1_ff;
   logic signed [PW-1:0] m2_ff;
   logic signed [PW:0]   diff;

   always_ff @(posedge clock) begin
      m1_ff <= a1 * b1;
      m2_ff <= a2 * b2;
   end

   assign diff      = (PW + 1)'(m1_ff) - (PW + 1)'(m2_ff);
   assign sign.neg  = diff[PW];
   assign sign.zero = (diff == '0);

endmodule

>>> hw/rtl/planar_convex_hull_engine.sv
// channel   dir  handshake              payload
// req       in   req_tvalid/req_tready  tdata: point_x, point_y; tlast: set_last
// rsp       out  rsp_tvalid/rsp_tready  tdata: hull_x, hull_y, hull_size; tlast: hull_end
//
// a point is inserted into the x-sorted point memory as it arrives, by the one-entry-per-cycle
// shift through the point memory port. after the marked point each chain tests every middle
// point (CH_GET, PART_MUL, PART_EVAL); a push on a stack of two or more first runs TURN_MUL
// and TURN_EVAL, a pop may reread the stack (POP_RD); results leave via EMIT_RD and EMIT_LD.
// synchronous reset clears the control state; memories need no clearing.
// req_tready is high only while idle; a stalled result holds the engine.
module planar_convex_hull_engine #(
   parameter int MAX_POINTS = 64,
   parameter int COORD_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // point_x, point_y
   input  logic [((2*COORD_BITS+7)/8)*8-1:0]      req_tdata,
   input  logic                                   req_tlast,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // hull_x, hull_y, hull_size
   output logic [((2*COORD_BITS+7+7)/8)*8-1:0]    rsp_tdata,
   output logic                                   rsp_tlast
);

   localparam int CB  = COORD_BITS;
   localparam int DW  = CB + 1;
   localparam int AW  = $clog2(MAX_POINTS);
   localparam int CW  = $clog2(MAX_POINTS + 1);
   localparam int SAW = $clog2(2 * MAX_POINTS);
   localparam int SZW = pch_pkg::HULL_SIZE_BITS;

   typedef struct packed {
      logic signed [CB-1:0] y;
      logic signed [CB-1:0] x;
   } point_type;

   point_type point_mem_ff [0:MAX_POINTS-1];
   point_type stack_mem_ff [0:2*MAX_POINTS-1];
   point_type pm_rdata_ff, st_rdata_ff;

   logic            pm_we, st_we;
   logic [AW-1:0]   pm_waddr, pm_raddr;
   logic [SAW-1:0]  st_waddr, st_raddr;
   point_type       pm_wdata, st_wdata;

   pch_pkg::state_type state_ff, state_in;
   logic [CW-1:0]   loaded_ff, loaded_in;
   logic            rsp_valid_ff, rsp_valid_in;

   point_type       e0_ff, e0_in, e1_ff, e1_in, pin_ff, pin_in, p_ff, p_in;
   point_type       left_ff, left_in, right_ff, right_in, t1_ff, t1_in, t2_ff, t2_in;
   logic            last_ff, last_in, upper_ff, upper_in, final_ff, final_in;
   logic [AW-1:0]   j_ff, j_in, i_ff, i_in, idx_ff, idx_in;
   logic [CW-1:0]   top_ff, top_in, topl_ff, topl_in, topu_ff, topu_in;
   logic [CW-1:0]   outk_ff, outk_in, size_ff, size_in;
   point_type       rsp_pt_ff, rsp_pt_in;
   logic [SZW-1:0]  rsp_size_ff, rsp_size_in;
   logic            rsp_end_ff, rsp_end_in;

   logic            req_fire, out_free, do_push, go_hull;
   point_type       req_pt;
   logic [CW-1:0]   top_m1, top_m3, top_p1, topu_m2;

   logic signed [DW-1:0]   op_a1, op_b1, op_a2, op_b2;
   pch_pkg::turn_sign_type xsign;

   function automatic logic [SAW-1:0] st_addr(input logic up, input logic [AW-1:0] ix);
      st_addr = up ? SAW'(MAX_POINTS) + SAW'(ix) : SAW'(ix);
   endfunction

   function automatic logic signed [DW-1:0] dsub(input logic signed [CB-1:0] a,
                                                 input logic signed [CB-1:0] b);
      dsub = DW'(a) - DW'(b);
   endfunction

   assign req_pt.x   = req_tdata[CB-1:0];
   assign req_pt.y   = req_tdata[2*CB-1:CB];
   assign req_tready = (state_ff == pch_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign top_m1     = top_ff - CW'(1);
   assign top_m3     = top_ff - CW'(3);
   assign top_p1     = top_ff + CW'(1);
   assign topu_m2    = topu_ff - CW'(2);

   // partition test against left-right line, or turn of (t2, p, t1)
   always_comb begin
      if (state_ff == pch_pkg::ST_PART_MUL) begin
         op_a1 = dsub(left_ff.x, right_ff.x);
         op_b1 = dsub(p_ff.y, right_ff.y);
         op_a2 = dsub(p_ff.x, right_ff.x);
         op_b2 = dsub(left_ff.y, right_ff.y);
      end else begin
         op_a1 = dsub(t2_ff.x, p_ff.x);
         op_b1 = dsub(t1_ff.y, p_ff.y);
         op_a2 = dsub(t1_ff.x, p_ff.x);
         op_b2 = dsub(t2_ff.y, p_ff.y);
      end
   end

   pch_cross #(.DW(DW)) u_cross (
      .clock (clock),
      .a1    (op_a1),
      .b1    (op_b1),
      .a2    (op_a2),
      .b2    (op_b2),
      .sign  (xsign)
   );

   always_comb begin
      state_in    = state_ff;
      loaded_in   = loaded_ff;
      e0_in       = e0_ff;
      e1_in       = e1_ff;
      pin_in      = pin_ff;
      p_in        = p_ff;
      left_in     = left_ff;
      right_in    = right_ff;
      t1_in       = t1_ff;
      t2_in       = t2_ff;
      last_in     = last_ff;
      upper_in    = upper_ff;
      final_in    = final_ff;
      j_in        = j_ff;
      i_in        = i_ff;
      idx_in      = idx_ff;
      top_in      = top_ff;
      topl_in     = topl_ff;
      topu_in     = topu_ff;
      outk_in     = outk_ff;
      size_in     = size_ff;
      rsp_pt_in   = rsp_pt_ff;
      rsp_size_in = rsp_size_ff;
      rsp_end_in  = rsp_end_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      pm_we       = 1'b0;
      pm_waddr    = '0;
      pm_wdata    = pin_ff;
      pm_raddr    = '0;
      st_we       = 1'b0;
      st_waddr    = '0;
      st_wdata    = p_ff;
      st_raddr    = '0;
      do_push     = 1'b0;
      go_hull     = 1'b0;

      unique case (state_ff)
         pch_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (loaded_ff < CW'(MAX_POINTS)) begin
                  loaded_in = loaded_ff + CW'(1);
                  pin_in    = req_pt;
                  last_in   = req_tlast;
                  if (loaded_ff == CW'(0)) e0_in = req_pt;
                  if (loaded_ff == CW'(1)) e1_in = req_pt;
                  if (loaded_ff == CW'(0)) begin
                     pm_we    = 1'b1;
                     pm_waddr = '0;
                     pm_wdata = req_pt;
                     go_hull  = req_tlast;
                  end else begin
                     pm_raddr = AW'(loaded_ff - CW'(1));
                     j_in     = AW'(loaded_ff - CW'(1));
                     state_in = pch_pkg::ST_INS_CMP;
                  end
               end else begin
                  // store full: the point is dropped
                  go_hull = req_tlast;
               end
            end
         end
         pch_pkg::ST_INS_CMP: begin
            if (pm_rdata_ff.x > pin_ff.x) begin
               pm_we    = 1'b1;
               pm_waddr = j_ff + AW'(1);
               pm_wdata = pm_rdata_ff;
               if (j_ff == '0) begin
                  state_in = pch_pkg::ST_INS_PUT;
               end else begin
                  pm_raddr = j_ff - AW'(1);
                  j_in     = j_ff - AW'(1);
               end
            end else begin
               pm_we    = 1'b1;
               pm_waddr = j_ff + AW'(1);
               pm_wdata = pin_ff;
               state_in = pch_pkg::ST_IDLE;
               go_hull  = last_ff;
            end
         end
         pch_pkg::ST_INS_PUT: begin
            pm_we    = 1'b1;
            pm_waddr = '0;
            pm_wdata = pin_ff;
            state_in = pch_pkg::ST_IDLE;
            go_hull  = last_ff;
         end
         pch_pkg::ST_LR0: begin
            pm_raddr = '0;
            state_in = pch_pkg::ST_LR1;
         end
         pch_pkg::ST_LR1: begin
            left_in  = pm_rdata_ff;
            pm_raddr = AW'(loaded_ff - CW'(1));
            state_in = pch_pkg::ST_LR2;
         end
         pch_pkg::ST_LR2: begin
            right_in = pm_rdata_ff;
            upper_in = 1'b0;
            state_in = pch_pkg::ST_CH_INIT;
         end
         pch_pkg::ST_CH_INIT: begin
            st_we    = 1'b1;
            st_waddr = st_addr(upper_ff, '0);
            st_wdata = left_ff;
            t1_in    = left_ff;
            top_in   = CW'(1);
            i_in     = AW'(1);
            final_in = 1'b0;
            state_in = pch_pkg::ST_CH_NEXT;
         end
         pch_pkg::ST_CH_NEXT: begin
            if (CW'(i_ff) + CW'(1) < loaded_ff) begin
               pm_raddr = i_ff;
               state_in = pch_pkg::ST_CH_GET;
            end else begin
               p_in     = right_ff;
               final_in = 1'b1;
               state_in = pch_pkg::ST_PUSH_CHK;
            end
         end
         pch_pkg::ST_CH_GET: begin
            p_in     = pm_rdata_ff;
            state_in = pch_pkg::ST_PART_MUL;
         end
         pch_pkg::ST_PART_MUL: begin
            state_in = pch_pkg::ST_PART_EVAL;
         end
         pch_pkg::ST_PART_EVAL: begin
            if (xsign.neg == upper_ff) begin
               state_in = pch_pkg::ST_PUSH_CHK;
            end else begin
               i_in     = i_ff + AW'(1);
               state_in = pch_pkg::ST_CH_NEXT;
            end
         end
         pch_pkg::ST_PUSH_CHK: begin
            if (top_ff >= CW'(2)) state_in = pch_pkg::ST_TURN_MUL;
            else do_push = 1'b1;
         end
         pch_pkg::ST_TURN_MUL: begin
            state_in = pch_pkg::ST_TURN_EVAL;
         end
         pch_pkg::ST_TURN_EVAL: begin
            // lower chain pops on a turn <= 0, upper chain on a turn >= 0
            if (upper_ff ? !xsign.neg : (xsign.neg || xsign.zero)) begin
               top_in = top_m1;
               t1_in  = t2_ff;
               if (top_m1 >= CW'(2)) begin
                  st_raddr = st_addr(upper_ff, top_m3[AW-1:0]);
                  state_in = pch_pkg::ST_POP_RD;
               end else begin
                  state_in = pch_pkg::ST_PUSH_CHK;
               end
            end else begin
               do_push = 1'b1;
            end
         end
         pch_pkg::ST_POP_RD: begin
            t2_in    = st_rdata_ff;
            state_in = pch_pkg::ST_PUSH_CHK;
         end
         pch_pkg::ST_EMIT_RD: begin
            if (out_free) begin
               st_raddr = st_addr(upper_ff, idx_ff);
               state_in = pch_pkg::ST_EMIT_LD;
            end
         end
         pch_pkg::ST_EMIT_LD: begin
            rsp_valid_in = 1'b1;
            rsp_pt_in    = st_rdata_ff;
            rsp_size_in  = SZW'(size_ff);
            rsp_end_in   = (outk_ff + CW'(1) == size_ff);
            outk_in      = outk_ff + CW'(1);
            if (!upper_ff) begin
               if (CW'(idx_ff) + CW'(1) < topl_ff) begin
                  idx_in = idx_ff + AW'(1);
               end else begin
                  upper_in = 1'b1;
                  idx_in   = topu_m2[AW-1:0];
               end
            end else begin
               idx_in = idx_ff - AW'(1);
            end
            if (outk_ff + CW'(1) == size_ff) begin
               loaded_in = '0;
               state_in  = pch_pkg::ST_IDLE;
            end else begin
               state_in  = pch_pkg::ST_EMIT_RD;
            end
         end
         pch_pkg::ST_ECHO: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_pt_in    = (outk_ff == '0) ? e0_ff : e1_ff;
               rsp_size_in  = SZW'(loaded_ff);
               rsp_end_in   = (outk_ff + CW'(1) == loaded_ff);
               outk_in      = outk_ff + CW'(1);
               if (outk_ff + CW'(1) == loaded_ff) begin
                  loaded_in = '0;
                  state_in  = pch_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = pch_pkg::ST_IDLE;
      endcase

      if (go_hull) begin
         outk_in  = '0;
         state_in = (loaded_in < CW'(3)) ? pch_pkg::ST_ECHO : pch_pkg::ST_LR0;
      end

      if (do_push) begin
         st_we    = 1'b1;
         st_waddr = st_addr(upper_ff, top_ff[AW-1:0]);
         st_wdata = p_ff;
         t2_in    = t1_ff;
         t1_in    = p_ff;
         top_in   = top_p1;
         if (final_ff) begin
            if (!upper_ff) begin
               topl_in  = top_p1;
               upper_in = 1'b1;
               state_in = pch_pkg::ST_CH_INIT;
            end else begin
               // upper chain starts and ends on the end points, both skipped
               topu_in  = top_p1;
               size_in  = topl_ff + top_p1 - CW'(2);
               outk_in  = '0;
               upper_in = 1'b0;
               idx_in   = '0;
               state_in = pch_pkg::ST_EMIT_RD;
            end
         end else begin
            i_in     = i_ff + AW'(1);
            state_in = pch_pkg::ST_CH_NEXT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pch_pkg::ST_IDLE;
         loaded_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         loaded_ff    <= loaded_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      e0_ff       <= e0_in;
      e1_ff       <= e1_in;
      pin_ff      <= pin_in;
      p_ff        <= p_in;
      left_ff     <= left_in;
      right_ff    <= right_in;
      t1_ff       <= t1_in;
      t2_ff       <= t2_in;
      last_ff     <= last_in;
      upper_ff    <= upper_in;
      final_ff    <= final_in;
      j_ff        <= j_in;
      i_ff        <= i_in;
      idx_ff      <= idx_in;
      top_ff      <= top_in;
      topl_ff     <= topl_in;
      topu_ff     <= topu_in;
      outk_ff     <= outk_in;
      size_ff     <= size_in;
      rsp_pt_ff   <= rsp_pt_in;
      rsp_size_ff <= rsp_size_in;
      rsp_end_ff  <= rsp_end_in;
   end

   always_ff @(posedge clock) begin
      if (pm_we) point_mem_ff[pm_waddr] <= pm_wdata;
      pm_rdata_ff <= point_mem_ff[pm_raddr];
   end

   always_ff @(posedge clock) begin
      if (st_we) stack_mem_ff[st_waddr] <= st_wdata;
      st_rdata_ff <= stack_mem_ff[st_raddr];
   end

   always_comb begin
      rsp_tdata                       = '0;
      rsp_tdata[CB-1:0]               = rsp_pt_ff.x;
      rsp_tdata[2*CB-1:CB]            = rsp_pt_ff.y;
      rsp_tdata[2*CB+SZW-1:2*CB]      = rsp_size_ff;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_end_ff;

endmodule

>>> hw/rtl/pch_checker.sv
`include "assert_macros.svh"

module pch_checker #(
   parameter int COORD_BITS = 16
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                req_tlast,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [((2*COORD_BITS+7+7)/8)*8-1:0] rsp_tdata,
   input logic                                rsp_tlast
);

   // a stalled word holds
   `AST_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
            rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

   // no new point is taken while a run is still being delivered
   `AST_IMP(a_busy_out, clock, reset, rsp_tvalid && !rsp_tlast, !req_tready)

   // an unmarked point never makes a result
   `AST_NXT(a_quiet_load, clock, reset,
            req_tvalid && req_tready && !req_tlast && !rsp_tvalid, !rsp_tvalid)

   // results only come from a run that was started
   `AST_NXT(a_idle_quiet, clock, reset,
            req_tready && !req_tvalid && !rsp_tvalid, !rsp_tvalid)

endmodule

bind planar_convex_hull_engine pch_checker #(.COORD_BITS(COORD_BITS)) u_pch_checker (.*);

>>> verif/testbench.sv
`timescale 1ns / 100ps

module testbench;

   localparam int MAX_PTS  = 64;
   localparam int CW       = 16;
   localparam int SZ_W     = pch_pkg::HULL_SIZE_BITS;
   localparam int REQ_W    = ((2*CW+7)/8)*8;
   localparam int RSP_W    = ((2*CW+7+7)/8)*8;
   localparam int CYCLE_LIMIT = 1500000;

   typedef struct {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
   } point_type;

   typedef struct {
      logic [CW-1:0]   x;
      logic [CW-1:0]   y;
      logic [SZ_W-1:0] size;
      logic            last;
   } vertex_type;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic             req_tlast;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tlast;

   planar_convex_hull_engine #(.MAX_POINTS(MAX_PTS), .COORD_BITS(CW)) u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );

   // predictor state
   point_type  loaded_pts[MAX_PTS];
   int         loaded_cnt;
   vertex_type hull_queue[$];
   int         err_count;
   int         cycle_count;
   int         stall_left;
   bit         stall_enable;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         cycle_count <= 0;
      end else begin
         cycle_count <= cycle_count + 1;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
         end
      end
   end

   function automatic int rand_gap();
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
      if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
      return 0;
   endfunction

   // sign of (a-b) x (c-b), exact in 64 bits for 16-bit coordinates
   function automatic int turn_of(point_type a, point_type b, point_type c);
      longint d;
      d = (longint'(a.x) - b.x) * (longint'(c.y) - b.y)
        - (longint'(c.x) - b.x) * (longint'(a.y) - b.y);
      return (d < 0) ? -1 : (d == 0) ? 0 : 1;
   endfunction

   function automatic void chain_add(ref point_type stk[MAX_PTS], ref int top,
                                     input point_type p, input int dir);
      if (top < MAX_PTS) begin
         stk[top] = p;
         top++;
      end
      while (top >= 3) begin
         if (dir * turn_of(stk[top-3], stk[top-1], stk[top-2]) <= 0) begin
            stk[top-2] = stk[top-1];
            top--;
         end else break;
      end
   endfunction

   function automatic void predict_hull();
      point_type srt[MAX_PTS], lo[MAX_PTS], up[MAX_PTS], stk[MAX_PTS], lft, rgt, p;
      point_type outv[$];
      int n, nl, nu, top, j;
      vertex_type v;
      n = loaded_cnt;
      nl = 0;
      nu = 0;
      loaded_cnt = 0;
      if (n < 3) begin
         for (int i = 0; i < n; i++) outv = {outv, loaded_pts[i]};
      end else begin
         for (int i = 0; i < n; i++) begin
            p = loaded_pts[i];
            j = i;
            while (j > 0 && srt[j-1].x > p.x) begin
               srt[j] = srt[j-1];
               j--;
            end
            srt[j] = p;
         end
         lft = srt[0];
         rgt = srt[n-1];
         for (int i = 1; i + 1 < n; i++) begin
            if (turn_of(lft, rgt, srt[i]) < 0) begin
               up[nu] = srt[i];
               nu++;
            end else begin
               lo[nl] = srt[i];
               nl++;
            end
         end
         top = 0;
         chain_add(stk, top, lft, 1);
         for (int i = 0; i < nl; i++) chain_add(stk, top, lo[i], 1);
         chain_add(stk, top, rgt, 1);
         for (int i = 0; i < top && outv.size() < MAX_PTS; i++) outv = {outv, stk[i]};
         top = 0;
         chain_add(stk, top, lft, -1);
         for (int i = 0; i < nu; i++) chain_add(stk, top, up[i], -1);
         chain_add(stk, top, rgt, -1);
         for (int i = top; i > 0 && outv.size() < MAX_PTS; i--) begin
            p = stk[i-1];
            if (!((p.x == lft.x && p.y == lft.y) || (p.x == rgt.x && p.y == rgt.y)))
               outv = {outv, p};
         end
      end
      foreach (outv[i]) begin
         v.x = outv[i].x;
         v.y = outv[i].y;
         v.size = SZ_W'(outv.size());
         v.last = (i == outv.size() - 1);
         hull_queue = {hull_queue, v};
      end
   endfunction

   task automatic send_point(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                             input bit last);
      int gap;
      gap = rand_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'({y, x});
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (loaded_cnt < MAX_PTS) begin
         loaded_pts[loaded_cnt].x = x;
         loaded_pts[loaded_cnt].y = y;
         loaded_cnt++;
      end
      if (last) predict_hull();
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (hull_queue.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // result checker
   always @(posedge clock) begin
      vertex_type e;
      if (reset) begin
         err_count  = 0;
         stall_left = 0;
         rsp_tready <= 1'b1;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (hull_queue.size() == 0) begin
               $display("%0t: unexpected word, actual %h last %b", $time, rsp_tdata, rsp_tlast);
               err_count++;
            end else begin
               e = hull_queue.pop_front();
               if (rsp_tdata[CW-1:0] !== e.x || rsp_tdata[2*CW-1:CW] !== e.y ||
                   rsp_tdata[2*CW +: SZ_W] !== e.size || rsp_tlast !== e.last) begin
                  $display("%0t: exp x %h y %h size %0d last %b, got x %h y %h size %0d last %b",
                           $time, e.x, e.y, e.size, e.last, rsp_tdata[CW-1:0],
                           rsp_tdata[2*CW-1:CW], rsp_tdata[2*CW +: SZ_W], rsp_tlast);
                  err_count++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (stall_enable && $urandom_range(0, 49) == 0) begin
            stall_left = $urandom_range(10, 40);
            rsp_tready <= 1'b0;
         end else if (stall_enable && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic test_small_sets();
      send_point(16'sd5, -16'sd7, 1'b1);
      send_point(16'sh7fff, 16'sh8000, 1'b0);
      send_point(16'sh8000, 16'sh7fff, 1'b1);
      send_point(16'sd0, 16'sd0, 1'b0);
      send_point(16'sd0, 16'sd0, 1'b0);
      send_point(16'sd0, 16'sd0, 1'b1);
   endtask

   task automatic test_extremes();
      send_point(16'sh8000, 16'sh8000, 1'b0);
      send_point(16'sh7fff, 16'sh8000, 1'b0);
      send_point(16'sh7fff, 16'sh7fff, 1'b0);
      send_point(16'sh8000, 16'sh7fff, 1'b0);
      send_point(16'sd0, 16'sd0, 1'b1);
      // collinear points and x ties
      send_point(16'sd1, 16'sd1, 1'b0);
      send_point(16'sd2, 16'sd2, 1'b0);
      send_point(16'sd3, 16'sd3, 1'b0);
      send_point(16'sd2, 16'sd9, 1'b0);
      send_point(16'sd2, -16'sd9, 1'b1);
      wait_drained();
   endtask

   task automatic test_full_store();
      // 66 points: last two dropped, marked one still starts the hull
      for (int i = 0; i < 66; i++)
         send_point(CW'($urandom()), CW'($urandom()), i == 65);
      wait_drained();
   endtask

   task automatic test_random_sets(input int count);
      int sent, n, span;
      sent = 0;
      while (sent < count) begin
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
         span = ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(4, 200);
         for (int i = 0; i < n; i++) begin
            if (span == 65535)
               send_point(CW'($urandom()), CW'($urandom()), i == n - 1);
            else
               send_point(CW'($urandom_range(0, span) - span/2),
                          CW'($urandom_range(0, span) - span/2), i == n - 1);
         end
         sent += n;
         if ($urandom_range(0, 7) == 0) wait_drained();
      end
   endtask

   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tlast    = 1'b0;
      loaded_cnt   = 0;
      stall_enable = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_small_sets();
      stall_enable = 1'b1;
      test_extremes();
      test_full_store();
      test_random_sets(140);
      wait_drained();
      repeat (100) @(posedge clock);
      if (err_count == 0 && hull_queue.size() == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
